FILE: src/fkg_pkg.sv
// Shared types, constants and state encoding for the fractional knapsack block.
`default_nettype none
package fkg_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int W_W = 16;
	localparam int V_W = 24;
	localparam int CAP_W = 22;
	localparam int TOT_W = 31;
	localparam int PCT_W = 7;
	localparam int PROD_W = W_W + V_W;
	localparam int NUM_W = CAP_W + V_W;
	localparam logic [6:0] PERCENT_SCALE = 7'd100;
	localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [W_W-1:0] item_weight;
		logic [V_W-1:0] item_value;
		logic last_item;
	} item_t;

	typedef struct packed {
		logic [TOT_W-1:0] total_value;
		logic [CAP_W-1:0] used_weight;
		logic partial_present;
		logic [PCT_W-1:0] partial_percent;
		logic [W_W-1:0] partial_weight;
		logic [V_W-1:0] partial_value;
	} result_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SORT_I, ST_RD_CUR, ST_RD_PREV, ST_CMP, ST_SHIFT,
		ST_PLACE, ST_FILL_RD, ST_FILL_RD2, ST_FILL, ST_DIV, ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic sort_init;
		logic rd_cur;
		logic rd_prev;
		logic cmp;
		logic shift;
		logic place;
		logic next_i;
		logic fill_init;
		logic fill_rd;
		logic fill_rd2;
		logic fill;
		logic div_start;
		logic div_step;
		logic emit;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic i_done;
		logic j_zero;
		logic above;
		logic fill_done;
		logic fits;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

FILE: src/fractional_knapsack_greedy.sv
// Top level of the fractional knapsack greedy solver.
// Items load one per cycle while busy is low; the transaction carrying last_item starts
// the solve, and busy stays high until the cycle of the single result strobe. The stable
// insertion sort runs through one store read port and one compare multiplier pair; the
// fill reads the sorted items in turn and the fraction comes from a bit-serial divide.
// The receiver cannot stall.
`default_nettype none
module fractional_knapsack_greedy import fkg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire item_t item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CAP_W-1:0] cfg_data,
	output logic result_strobe,
	output result_t result
);

	cmd_t cmd;
	status_t st;
	logic [CAP_W-1:0] capacity_q;

	// Capacity register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= '0;
		else if (cfg_valid && cfg_ready) capacity_q <= cfg_data;
	end

	fkg_ctrl u_ctrl (.clk, .arst_n, .start, .last_item(item.last_item), .st, .busy, .cmd);
	fkg_dp u_dp (.clk, .arst_n, .item, .capacity(capacity_q), .cmd, .st,
		.result_valid(result_strobe), .result);

endmodule
`default_nettype wire

FILE: src/fkg_ctrl.sv
// Controller state machine sequencing load, insertion sort, greedy fill and division.
`default_nettype none
module fkg_ctrl import fkg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic last_item,
	input wire status_t st,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (start && last_item) state_d = ST_SORT_I;
			ST_SORT_I: state_d = st.i_done ? ST_FILL_RD : ST_RD_CUR;
			ST_RD_CUR: state_d = ST_RD_PREV;
			ST_RD_PREV: state_d = st.j_zero ? ST_PLACE : ST_CMP;
			ST_CMP: state_d = ST_SHIFT;
			ST_SHIFT: state_d = st.above ? ST_RD_PREV : ST_PLACE;
			ST_PLACE: state_d = ST_SORT_I;
			ST_FILL_RD: state_d = st.fill_done ? ST_DONE : ST_FILL_RD2;
			ST_FILL_RD2: state_d = ST_FILL;
			ST_FILL: state_d = st.fits ? ST_FILL_RD : ST_DIV;
			ST_DIV: if (st.div_done) state_d = ST_DONE;
			ST_DONE: state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				busy = 1'b0;
				cmd.load = start;
				cmd.sort_init = start && last_item;
			end
			ST_SORT_I: cmd.fill_init = st.i_done;
			ST_RD_CUR: cmd.rd_cur = 1'b1;
			ST_RD_PREV: cmd.rd_prev = 1'b1;
			ST_CMP: cmd.cmp = 1'b1;
			ST_SHIFT: cmd.shift = st.above;
			ST_PLACE: begin
				cmd.place = 1'b1;
				cmd.next_i = 1'b1;
			end
			ST_FILL_RD: cmd.fill_rd = 1'b1;
			ST_FILL_RD2: cmd.fill_rd2 = 1'b1;
			ST_FILL: begin
				cmd.fill = 1'b1;
				cmd.div_start = !st.fits;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_DONE: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	// A result strobe only leaves the done state.
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_DONE) else $error("emit outside done");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> !busy) else $error("not idle after done");
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy) else $error("not busy after last");

endmodule
`default_nettype wire

FILE: src/fkg_dp.sv
// Datapath: item stores, order memory, ratio compare, greedy accumulator and divider.
`default_nettype none
module fkg_dp import fkg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire logic [CAP_W-1:0] capacity,
	input wire cmd_t cmd,
	output status_t st,
	output logic result_valid,
	output result_t result
);

	logic [W_W-1:0] wmem [MAX_ITEMS];
	logic [V_W-1:0] vmem [MAX_ITEMS];
	logic [IDX_W-1:0] omem [MAX_ITEMS];

	logic [CNT_W-1:0] count_q, i_q, j_q, k_q;
	logic [W_W-1:0] w_rd_q, cw_q;
	logic [V_W-1:0] v_rd_q, cv_q;
	logic [IDX_W-1:0] o_rd_q;
	logic [PROD_W-1:0] lhs_q, rhs_q;
	logic above_q;
	logic [CAP_W-1:0] used_q, left_q;
	logic [TOT_W+1:0] total_q;
	logic present_q;
	logic [W_W-1:0] pw_q;
	logic [V_W-1:0] pv_q;
	// Restoring divider: two quotients share one shift sequence length.
	logic [NUM_W-1:0] numv_q;
	logic [CAP_W+PCT_W-1:0] nump_q;
	logic [W_W:0] remv_q, remp_q;
	logic [5:0] dcnt_q;
	logic [W_W:0] remv_sh, remp_sh;
	logic [IDX_W-1:0] rd_addr;
	logic [CAP_W:0] used_plus;

	// Store writes and read port address.
	always_comb begin
		rd_addr = o_rd_q;
		if (cmd.rd_cur) rd_addr = i_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CNT_W'(MAX_ITEMS)) begin
			wmem[count_q[IDX_W-1:0]] <= item.item_weight;
			vmem[count_q[IDX_W-1:0]] <= item.item_value;
		end
		w_rd_q <= wmem[rd_addr];
		v_rd_q <= vmem[rd_addr];
	end

	// Order memory: read at k, or at one below the next value of j, written on shift
	// and place.
	always_ff @(posedge clk) begin
		if (cmd.shift) omem[j_q[IDX_W-1:0]] <= o_rd_q;
		else if (cmd.place) omem[j_q[IDX_W-1:0]] <= i_q[IDX_W-1:0];
		if (cmd.fill_rd) o_rd_q <= omem[k_q[IDX_W-1:0]];
		else if (cmd.rd_cur) o_rd_q <= omem[IDX_W'(i_q - 1'b1)];
		else if (cmd.shift) o_rd_q <= omem[IDX_W'(j_q - 2'd2)];
		else o_rd_q <= omem[IDX_W'(j_q - 1'b1)];
	end

	// Counters and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cmd.load && count_q < CNT_W'(MAX_ITEMS)) count_q <= count_q + 1'b1;
			if (cmd.sort_init) i_q <= '0;
			if (cmd.rd_cur) j_q <= i_q;
			if (cmd.shift) j_q <= j_q - 1'b1;
			if (cmd.next_i) i_q <= i_q + 1'b1;
			if (cmd.fill_init) k_q <= '0;
			if (cmd.fill && st.fits) k_q <= k_q + 1'b1;
			if (cmd.emit) count_q <= '0;
		end
	end

	// Compare path: current item held, previous read, products registered.
	always_ff @(posedge clk) begin
		if (cmd.rd_prev && j_q == i_q) begin
			cw_q <= w_rd_q;
			cv_q <= v_rd_q;
		end
		if (cmd.cmp) begin
			lhs_q <= PROD_W'(cv_q) * PROD_W'(w_rd_q);
			rhs_q <= PROD_W'(v_rd_q) * PROD_W'(cw_q);
		end
	end
	assign above_q = lhs_q > rhs_q;

	// Greedy fill and divider.
	assign used_plus = {1'b0, used_q} + (CAP_W+1)'(w_rd_q);
	assign remv_sh = {remv_q[W_W-1:0], numv_q[NUM_W-1]};
	assign remp_sh = {remp_q[W_W-1:0], nump_q[CAP_W+PCT_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.fill_init) begin
			used_q <= '0;
			total_q <= '0;
			present_q <= 1'b0;
			pw_q <= '0;
			pv_q <= '0;
		end
		if (cmd.fill) begin
			if (st.fits) begin
				used_q <= used_plus[CAP_W-1:0];
				total_q <= total_q + (TOT_W+2)'(v_rd_q);
			end else begin
				left_q <= capacity - used_q;
			end
		end
		if (cmd.div_start) begin
			numv_q <= NUM_W'(capacity - used_q) * NUM_W'(v_rd_q);
			nump_q <= (CAP_W+PCT_W)'(capacity - used_q) * (CAP_W+PCT_W)'(PERCENT_SCALE);
			remv_q <= '0;
			remp_q <= '0;
			dcnt_q <= '0;
			pw_q <= w_rd_q;
			pv_q <= v_rd_q;
		end
		if (cmd.div_step && !st.div_done) begin
			dcnt_q <= dcnt_q + 1'b1;
			numv_q <= {numv_q[NUM_W-2:0], (remv_sh >= {1'b0, pw_q})};
			remv_q <= (remv_sh >= {1'b0, pw_q}) ? remv_sh - {1'b0, pw_q} : remv_sh;
			if (dcnt_q >= 6'(NUM_W - CAP_W - PCT_W)) begin
				nump_q <= {nump_q[CAP_W+PCT_W-2:0], (remp_sh >= {1'b0, pw_q})};
				remp_q <= (remp_sh >= {1'b0, pw_q}) ? remp_sh - {1'b0, pw_q} : remp_sh;
			end
		end
		if (cmd.div_step && st.div_done) begin
			present_q <= left_q != '0;
			total_q <= total_q + (TOT_W+2)'(numv_q);
		end
	end

	// Status to the controller.
	assign st.i_done = i_q >= count_q;
	assign st.j_zero = j_q == '0;
	assign st.above = above_q;
	assign st.fill_done = k_q >= count_q;
	assign st.fits = used_plus <= {1'b0, capacity};
	assign st.div_done = dcnt_q == 6'(NUM_W);

	// Result assembly; a zero leftover reports no partial item.
	always_comb begin
		result.total_value = (total_q > (TOT_W+2)'(TOTAL_MAX)) ? TOTAL_MAX : total_q[TOT_W-1:0];
		result.used_weight = used_q;
		result.partial_present = present_q;
		result.partial_percent = present_q ? nump_q[PCT_W-1:0] : '0;
		result.partial_weight = present_q ? pw_q : '0;
		result.partial_value = present_q ? pv_q : '0;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS)) else $error("count overflow");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count_q == '0) else $error("count not cleared");
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> used_q <= capacity) else $error("used above capacity");

endmodule
`default_nettype wire
